### rtl/dstr_pkg.sv
package dstr_pkg;

    localparam int TS_WIDTH   = 40;
    localparam int ADDR_WIDTH = 8;
    localparam int FUNC_WIDTH = 2;
    localparam int TOF_WIDTH  = 42;
    localparam int DEN_WIDTH  = TS_WIDTH + 2;
    localparam int PROD_WIDTH = 2 * TS_WIDTH;

    localparam int MUL_CNT_WIDTH = $clog2(TS_WIDTH + 1);
    localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH + 1);

    // Event kinds carried in the func field.
    localparam logic [FUNC_WIDTH-1:0] FUNC_POLL  = FUNC_WIDTH'(0);
    localparam logic [FUNC_WIDTH-1:0] FUNC_REPLY = FUNC_WIDTH'(1);
    localparam logic [FUNC_WIDTH-1:0] FUNC_RANGE = FUNC_WIDTH'(2);

    // Status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ZERO_DEN = 1'b1;

    // Largest positive time of flight and largest negative magnitude.
    localparam logic [PROD_WIDTH-1:0] TOF_MAXPOS =
        {{(PROD_WIDTH - TOF_WIDTH + 1){1'b0}}, {(TOF_WIDTH - 1){1'b1}}};
    localparam logic [PROD_WIDTH-1:0] TOF_MAXNEG = TOF_MAXPOS + PROD_WIDTH'(1);

endpackage

### rtl/dstr_if.sv
interface dstr_evt_if import dstr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_WIDTH-1:0] func;
    logic [ADDR_WIDTH-1:0] src_addr;
    logic [TS_WIDTH-1:0]   local_time;
    logic [TS_WIDTH-1:0]   remote_poll_tx;
    logic [TS_WIDTH-1:0]   remote_reply_rx;
    logic [TS_WIDTH-1:0]   remote_range_tx;

    modport source
    (
        output valid, func, src_addr, local_time,
        output remote_poll_tx, remote_reply_rx, remote_range_tx,
        input  ready
    );

    modport sink
    (
        input  valid, func, src_addr, local_time,
        input  remote_poll_tx, remote_reply_rx, remote_range_tx,
        output ready
    );
endinterface

interface dstr_rng_if import dstr_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [TOF_WIDTH-1:0] tof_ticks;
    logic [ADDR_WIDTH-1:0]       peer_addr;
    logic                        status;

    modport source
    (
        output valid, tof_ticks, peer_addr, status,
        input  ready
    );

    modport sink
    (
        input  valid, tof_ticks, peer_addr, status,
        output ready
    );
endinterface

### rtl/dstr_mul.sv
// Serial shift-and-add multiplier: one multiplier bit per cycle, LSB first.
module dstr_mul import dstr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [TS_WIDTH-1:0]   a,
    input  logic [TS_WIDTH-1:0]   b,
    output logic                  busy,
    output logic [PROD_WIDTH-1:0] product
);

    logic [TS_WIDTH-1:0]      mcand_reg;
    logic [PROD_WIDTH-1:0]    prod_reg;
    logic [MUL_CNT_WIDTH-1:0] cnt_reg;
    logic                     busy_reg;
    logic [TS_WIDTH:0]        sum;

    // The upper half accumulates; the multiplier drains out of the lower half.
    assign sum = {1'b0, prod_reg[PROD_WIDTH-1:TS_WIDTH]}
               + (prod_reg[0] ? {1'b0, mcand_reg} : {(TS_WIDTH + 1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= MUL_CNT_WIDTH'(TS_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - MUL_CNT_WIDTH'(1);
            if (cnt_reg == MUL_CNT_WIDTH'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= a;
            prod_reg  <= {{TS_WIDTH{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[TS_WIDTH-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule

### rtl/dstr_div.sv
// Restoring divider: one quotient bit per cycle, the quotient shifts in
// behind the dividend.
module dstr_div import dstr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PROD_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0]  den,
    output logic                  busy,
    output logic [PROD_WIDTH-1:0] quot
);

    logic [PROD_WIDTH-1:0]    num_reg;
    logic [DEN_WIDTH-1:0]     rem_reg;
    logic [DEN_WIDTH-1:0]     den_reg;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg;
    logic                     busy_reg;
    logic [DEN_WIDTH:0]       shifted;
    logic [DEN_WIDTH+1:0]     trial;
    logic                     fits;

    assign shifted = {rem_reg, num_reg[PROD_WIDTH-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~trial[DEN_WIDTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_WIDTH'(PROD_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_WIDTH'(1);
            if (cnt_reg == DIV_CNT_WIDTH'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[PROD_WIDTH-2:0], fits};
            rem_reg <= fits ? trial[DEN_WIDTH-1:0] : shifted[DEN_WIDTH-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

### rtl/ds_twr_responder_tof.sv
// Responder side of asymmetric double-sided two-way ranging.
// Events enter on the evt channel (valid/ready). A poll stores the sender as
// the peer and the local receive time; a reply-sent event stores the local
// transmit time. Neither gives a result. A range event from the stored peer
// yields one item on the rng channel: the time of flight in ticks,
// (round1*round2 - reply1*reply2) / (sum of the four intervals), truncated
// toward zero and clipped to the signed range, with the peer address and a
// status bit. A range event from another sender and an unused event kind
// are dropped. A range item passes through the two serial multipliers, which
// run side by side, and then through the serial divider before its result is
// valid. A zero denominator skips both and reports status 1.
// Only one event is in work at a time, so no new event is taken before the last
// range item has reached the output register; evt.ready is high whenever the
// datapath is free.
// The result sits in an output register, so new events are taken while the
// receiver stalls; a range item that finishes while the previous result is
// still unread waits until that result is taken.
// Reset clears the peer and both stored times to zero and empties the block.
module ds_twr_responder_tof import dstr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    dstr_evt_if.sink   evt,
    dstr_rng_if.source rng
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DIFF,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Ranging context.
    logic [ADDR_WIDTH-1:0] peer_reg;
    logic [TS_WIDTH-1:0]   poll_rx_reg;
    logic [TS_WIDTH-1:0]   reply_tx_reg;

    // Working registers for one range item.
    logic [TS_WIDTH-1:0]  round1_reg;
    logic [TS_WIDTH-1:0]  round2_reg;
    logic [TS_WIDTH-1:0]  reply1_reg;
    logic [TS_WIDTH-1:0]  reply2_reg;
    logic [DEN_WIDTH-1:0] den_reg;
    logic                 neg_reg;
    logic                 zero_den_reg;
    logic [TOF_WIDTH-1:0] sat_reg;

    // Output register.
    logic                        out_valid_reg;
    logic signed [TOF_WIDTH-1:0] tof_reg;
    logic [ADDR_WIDTH-1:0]       peer_out_reg;
    logic                        status_reg;

    logic                  accept;
    logic                  range_hit;
    logic                  den_zero;
    logic [DEN_WIDTH-1:0]  den_sum;
    logic                  mul_start;
    logic                  mul_p_busy;
    logic                  mul_n_busy;
    logic [PROD_WIDTH-1:0] prod_p;
    logic [PROD_WIDTH-1:0] prod_n;
    logic [PROD_WIDTH:0]   diff_pn;
    logic [PROD_WIDTH-1:0] diff_np;
    logic [PROD_WIDTH-1:0] mag;
    logic                  div_start;
    logic                  div_busy;
    logic [PROD_WIDTH-1:0] quot;
    logic [PROD_WIDTH-1:0] quot_clip;
    logic                  out_load;

    assign evt.ready = (state_reg == ST_IDLE);
    assign accept    = evt.valid && evt.ready;
    assign range_hit = (evt.func == FUNC_RANGE) && (evt.src_addr == peer_reg);

    // A finished item moves into the output register once it is free or
    // being emptied in the same cycle.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || rng.ready);

    // All intervals are non-negative, so the sum is zero only if each one is.
    assign den_zero = ~|{round1_reg, round2_reg, reply1_reg, reply2_reg};
    assign den_sum  = DEN_WIDTH'(round1_reg) + DEN_WIDTH'(round2_reg)
                    + DEN_WIDTH'(reply1_reg) + DEN_WIDTH'(reply2_reg);

    assign mul_start = (state_reg == ST_SUM) && !den_zero;

    dstr_mul u_mul_p
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (round1_reg),
        .b       (round2_reg),
        .busy    (mul_p_busy),
        .product (prod_p)
    );

    dstr_mul u_mul_n
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (reply1_reg),
        .b       (reply2_reg),
        .busy    (mul_n_busy),
        .product (prod_n)
    );

    // Signed difference of the two products as sign and magnitude.
    assign diff_pn = {1'b0, prod_p} - {1'b0, prod_n};
    assign diff_np = prod_n - prod_p;
    assign mag     = diff_pn[PROD_WIDTH] ? diff_np : diff_pn[PROD_WIDTH-1:0];

    assign div_start = (state_reg == ST_DIFF);

    dstr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    // Clip the quotient magnitude to what the signed result can carry.
    always_comb
    begin
        quot_clip = quot;
        if (neg_reg && (quot > TOF_MAXNEG))
        begin
            quot_clip = TOF_MAXNEG;
        end
        else if (!neg_reg && (quot > TOF_MAXPOS))
        begin
            quot_clip = TOF_MAXPOS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peer_reg      <= '0;
            poll_rx_reg   <= '0;
            reply_tx_reg  <= '0;
            round1_reg    <= '0;
            round2_reg    <= '0;
            reply1_reg    <= '0;
            reply2_reg    <= '0;
            den_reg       <= '0;
            neg_reg       <= 1'b0;
            zero_den_reg  <= 1'b0;
            sat_reg       <= '0;
            out_valid_reg <= 1'b0;
            tof_reg       <= '0;
            peer_out_reg  <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rng.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (evt.func == FUNC_POLL)
                        begin
                            peer_reg    <= evt.src_addr;
                            poll_rx_reg <= evt.local_time;
                        end
                        else if (evt.func == FUNC_REPLY)
                        begin
                            reply_tx_reg <= evt.local_time;
                        end
                        else if (range_hit)
                        begin
                            round1_reg <= evt.remote_reply_rx - evt.remote_poll_tx;
                            reply1_reg <= reply_tx_reg - poll_rx_reg;
                            round2_reg <= evt.local_time - reply_tx_reg;
                            reply2_reg <= evt.remote_range_tx - evt.remote_reply_rx;
                            state_reg  <= ST_SUM;
                        end
                    end
                end

                ST_SUM:
                begin
                    den_reg <= den_sum;
                    if (den_zero)
                    begin
                        zero_den_reg <= 1'b1;
                        neg_reg      <= 1'b0;
                        sat_reg      <= '0;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        zero_den_reg <= 1'b0;
                        state_reg    <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    if (!mul_p_busy && !mul_n_busy)
                    begin
                        state_reg <= ST_DIFF;
                    end
                end

                ST_DIFF:
                begin
                    neg_reg   <= diff_pn[PROD_WIDTH];
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_SAT;
                    end
                end

                ST_SAT:
                begin
                    sat_reg   <= quot_clip[TOF_WIDTH-1:0];
                    state_reg <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (out_load)
                    begin
                        tof_reg       <= neg_reg ? $signed(~sat_reg + TOF_WIDTH'(1))
                                                 : $signed(sat_reg);
                        peer_out_reg  <= peer_reg;
                        status_reg    <= zero_den_reg ? STATUS_ZERO_DEN : STATUS_OK;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rng.valid     = out_valid_reg;
    assign rng.tof_ticks = tof_reg;
    assign rng.peer_addr = peer_out_reg;
    assign rng.status    = status_reg;

`ifndef ASSERT_OFF
    a_zero_den_tof: assert property (@(posedge clk) disable iff (!rst_n)
        rng.valid && (rng.status == STATUS_ZERO_DEN) |-> rng.tof_ticks == '0)
        else $error("zero-denominator result carries a nonzero time of flight");

    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> den_reg != '0)
        else $error("divider running with a zero divisor");

    a_peer_by_poll: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(peer_reg) |-> $past(evt.valid && evt.ready && evt.func == FUNC_POLL))
        else $error("peer changed without an accepted poll");

    a_mul_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        mul_p_busy != mul_n_busy |-> 1'b0)
        else $error("the two multipliers are out of step");
`endif

endmodule
